[src/tacu_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tacu_pkg
// Shared types and constants for the tabular actor-critic update block.
// ----------------------------------------------------------------------------
package tacu_pkg;

    localparam int DEF_GRID_ROWS = 32;
    localparam int DEF_GRID_COLS = 32;

    localparam int COORD_W     = 5;
    localparam int ACT_W       = 2;
    localparam int NUM_ACTIONS = 4;
    localparam int VAL_W       = 24;
    localparam int PREF_W      = 23;
    localparam int RATE_W      = 17;
    localparam int CFG_IDX_W   = 3;

    localparam logic [RATE_W-1:0] Q_ONE = 17'd65536;

    localparam logic [RATE_W-1:0] DISCOUNT_RST    = 17'd62259;
    localparam logic [RATE_W-1:0] CRITIC_RATE_RST = 17'd6554;
    localparam logic [RATE_W-1:0] ACTOR_RATE_RST  = 17'd655;
    localparam logic [RATE_W-1:0] PREF_FLOOR_RST  = 17'd655;

    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITIC_RATE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTOR_RATE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PREF_FLOOR  = 3'd3;

    localparam logic [VAL_W-1:0] VAL_ZERO = 24'd0;
    localparam logic [VAL_W-1:0] PREF_RST = 24'd65536;

    typedef logic [NUM_ACTIONS-1:0][VAL_W-1:0] pref_row_t;

    typedef struct packed {
        logic [RATE_W-1:0] discount;
        logic [RATE_W-1:0] critic_rate;
        logic [RATE_W-1:0] actor_rate;
        logic [RATE_W-1:0] pref_floor;
    } cfg_t;

endpackage
`default_nettype wire

[src/tacu_critic_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tacu_critic_mem
// Critic value store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module tacu_critic_mem #(
    parameter int DEPTH = tacu_pkg::DEF_GRID_ROWS * tacu_pkg::DEF_GRID_COLS
) (
    input  wire logic                         aclk,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  wire logic [tacu_pkg::VAL_W-1:0]   wr_data,
    input  wire logic                         rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]     rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0]     rd_addr_b,
    output logic      [tacu_pkg::VAL_W-1:0]   rd_data_a,
    output logic      [tacu_pkg::VAL_W-1:0]   rd_data_b
);

    logic [tacu_pkg::VAL_W-1:0] mem [DEPTH];
    logic [tacu_pkg::VAL_W-1:0] rd_a_reg;
    logic [tacu_pkg::VAL_W-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule
`default_nettype wire

[src/tacu_pref_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tacu_pref_mem
// Actor preference store: one row of four action preferences per cell.
// ----------------------------------------------------------------------------
module tacu_pref_mem #(
    parameter int DEPTH = tacu_pkg::DEF_GRID_ROWS * tacu_pkg::DEF_GRID_COLS
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire tacu_pkg::pref_row_t      wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output tacu_pkg::pref_row_t           rd_data
);

    tacu_pkg::pref_row_t mem [DEPTH];
    tacu_pkg::pref_row_t rd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_reg;

endmodule
`default_nettype wire

[src/tacu_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tacu_ctrl
// Sequencer and arithmetic: clear pass, table reads, TD error through a
// shared multiplier, write-back and result register.
// ----------------------------------------------------------------------------
module tacu_ctrl #(
    parameter int GRID_ROWS = tacu_pkg::DEF_GRID_ROWS,
    parameter int GRID_COLS = tacu_pkg::DEF_GRID_COLS
) (
    input  wire logic                                         aclk,
    input  wire logic                                         aresetn,
    input  wire tacu_pkg::cfg_t                               cfg,
    input  wire logic                                         s_valid,
    output logic                                              s_ready,
    input  wire logic [tacu_pkg::COORD_W-1:0]                 s_cur_row,
    input  wire logic [tacu_pkg::COORD_W-1:0]                 s_cur_col,
    input  wire logic [tacu_pkg::ACT_W-1:0]                   s_action,
    input  wire logic signed [tacu_pkg::VAL_W-1:0]            s_reward,
    input  wire logic [tacu_pkg::COORD_W-1:0]                 s_next_row,
    input  wire logic [tacu_pkg::COORD_W-1:0]                 s_next_col,
    output logic                                              m_valid,
    input  wire logic                                         m_ready,
    output logic signed [tacu_pkg::VAL_W-1:0]                 m_td_error,
    output logic signed [tacu_pkg::VAL_W-1:0]                 m_new_state_value,
    output logic [tacu_pkg::PREF_W-1:0]                       m_new_preference,
    output logic                                              crit_rd_en,
    output logic [$clog2(GRID_ROWS*GRID_COLS)-1:0]            crit_rd_addr_a,
    output logic [$clog2(GRID_ROWS*GRID_COLS)-1:0]            crit_rd_addr_b,
    input  wire logic [tacu_pkg::VAL_W-1:0]                   crit_rd_data_a,
    input  wire logic [tacu_pkg::VAL_W-1:0]                   crit_rd_data_b,
    output logic                                              crit_wr_en,
    output logic [$clog2(GRID_ROWS*GRID_COLS)-1:0]            crit_wr_addr,
    output logic [tacu_pkg::VAL_W-1:0]                        crit_wr_data,
    output logic                                              pref_rd_en,
    output logic [$clog2(GRID_ROWS*GRID_COLS)-1:0]            pref_rd_addr,
    input  wire tacu_pkg::pref_row_t                          pref_rd_data,
    output logic                                              pref_wr_en,
    output logic [$clog2(GRID_ROWS*GRID_COLS)-1:0]            pref_wr_addr,
    output tacu_pkg::pref_row_t                               pref_wr_data
);

    localparam int NCELLS   = GRID_ROWS * GRID_COLS;
    localparam int CELL_W   = $clog2(NCELLS);
    localparam int ROW_LAST = GRID_ROWS - 1;
    localparam int COL_LAST = GRID_COLS - 1;
    localparam int PROD_W   = tacu_pkg::RATE_W + 1 + tacu_pkg::VAL_W;
    localparam int RND_W    = PROD_W - 16;
    localparam int SUM_W    = 28;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_MULD  = 7'b0000100,
        ST_TD    = 7'b0001000,
        ST_MULC  = 7'b0010000,
        ST_MULA  = 7'b0100000,
        ST_UPD   = 7'b1000000
    } state_t;

    function automatic logic [tacu_pkg::COORD_W-1:0] sat_coord(
        input logic [tacu_pkg::COORD_W-1:0] c,
        input int                           last
    );
        if (32'(c) > last) begin
            return tacu_pkg::COORD_W'(last);
        end
        return c;
    endfunction

    function automatic logic signed [RND_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] biased;
        biased = p + PROD_W'(32768);
        return $signed(biased[PROD_W-1:16]);
    endfunction

    function automatic logic signed [tacu_pkg::VAL_W-1:0] sat_val(
        input logic signed [SUM_W-1:0] x
    );
        if (x > SUM_W'(8388607)) begin
            return 24'sh7FFFFF;
        end else if (x < -SUM_W'(8388608)) begin
            return 24'sh800000;
        end
        return x[tacu_pkg::VAL_W-1:0];
    endfunction

    state_t                              state_reg, state_next;
    logic [CELL_W-1:0]                   clr_cnt_reg, clr_cnt_next;
    logic [CELL_W-1:0]                   cur_reg, cur_next;
    logic [tacu_pkg::ACT_W-1:0]          act_reg, act_next;
    logic signed [tacu_pkg::VAL_W-1:0]   reward_reg, reward_next;
    logic signed [tacu_pkg::VAL_W-1:0]   td_reg, td_next;
    logic signed [PROD_W-1:0]            prod_reg, prod_next;
    logic signed [tacu_pkg::VAL_W-1:0]   nv_reg, nv_next;
    logic                                m_valid_reg, m_valid_next;
    logic signed [tacu_pkg::VAL_W-1:0]   m_td_reg, m_td_next;
    logic signed [tacu_pkg::VAL_W-1:0]   m_nv_reg, m_nv_next;
    logic [tacu_pkg::PREF_W-1:0]         m_np_reg, m_np_next;

    logic                                accept;
    logic                                out_free;
    logic [CELL_W-1:0]                   cur_idx;
    logic [CELL_W-1:0]                   nxt_idx;
    logic [tacu_pkg::RATE_W-1:0]         mul_rate;
    logic signed [tacu_pkg::VAL_W-1:0]   mul_opnd;
    logic signed [PROD_W-1:0]            mul_out;
    logic signed [RND_W-1:0]             prod_rnd;
    logic signed [SUM_W-1:0]             td_sum;
    logic signed [SUM_W-1:0]             nv_sum;
    logic signed [SUM_W-1:0]             np_sum;
    logic signed [tacu_pkg::VAL_W-1:0]   np_sat;
    logic signed [tacu_pkg::VAL_W-1:0]   floor_val;
    logic signed [tacu_pkg::VAL_W-1:0]   np_val;
    tacu_pkg::pref_row_t                 row_upd;

    assign cur_idx = CELL_W'(sat_coord(s_cur_row, ROW_LAST)) * CELL_W'(GRID_COLS)
                   + CELL_W'(sat_coord(s_cur_col, COL_LAST));
    assign nxt_idx = CELL_W'(sat_coord(s_next_row, ROW_LAST)) * CELL_W'(GRID_COLS)
                   + CELL_W'(sat_coord(s_next_col, COL_LAST));

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // shared multiplier: discount, then critic rate, then actor rate
    always_comb begin
        case (state_reg)
            ST_MULD: begin
                mul_rate = cfg.discount;
                mul_opnd = $signed(crit_rd_data_b);
            end
            ST_MULC: begin
                mul_rate = cfg.critic_rate;
                mul_opnd = td_reg;
            end
            default: begin
                mul_rate = cfg.actor_rate;
                mul_opnd = td_reg;
            end
        endcase
    end

    assign mul_out  = $signed({1'b0, mul_rate}) * mul_opnd;
    assign prod_rnd = round_q16(prod_reg);

    assign td_sum = SUM_W'(reward_reg) + SUM_W'(prod_rnd)
                  - SUM_W'($signed(crit_rd_data_a));
    assign nv_sum = SUM_W'($signed(crit_rd_data_a)) + SUM_W'(prod_rnd);
    assign np_sum = SUM_W'($signed(pref_rd_data[act_reg])) + SUM_W'(prod_rnd);
    assign np_sat    = sat_val(np_sum);
    assign floor_val = $signed({7'd0, cfg.pref_floor});
    assign np_val    = (np_sat < floor_val) ? floor_val : np_sat;

    always_comb begin
        row_upd          = pref_rd_data;
        row_upd[act_reg] = np_val;
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        cur_next     = cur_reg;
        act_next     = act_reg;
        reward_next  = reward_reg;
        td_next      = td_reg;
        prod_next    = prod_reg;
        nv_next      = nv_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_td_next    = m_td_reg;
        m_nv_next    = m_nv_reg;
        m_np_next    = m_np_reg;

        crit_rd_en     = accept;
        crit_rd_addr_a = cur_idx;
        crit_rd_addr_b = nxt_idx;
        pref_rd_en     = accept;
        pref_rd_addr   = cur_idx;
        crit_wr_en     = 1'b0;
        crit_wr_addr   = cur_reg;
        crit_wr_data   = nv_reg;
        pref_wr_en     = 1'b0;
        pref_wr_addr   = cur_reg;
        pref_wr_data   = row_upd;

        case (state_reg)
            ST_CLEAR: begin
                crit_wr_en   = 1'b1;
                crit_wr_addr = clr_cnt_reg;
                crit_wr_data = tacu_pkg::VAL_ZERO;
                pref_wr_en   = 1'b1;
                pref_wr_addr = clr_cnt_reg;
                pref_wr_data = {tacu_pkg::NUM_ACTIONS{tacu_pkg::PREF_RST}};
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CELL_W'(NCELLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    cur_next    = cur_idx;
                    act_next    = s_action;
                    reward_next = s_reward;
                    state_next  = ST_MULD;
                end
            end
            ST_MULD: begin
                prod_next  = mul_out;
                state_next = ST_TD;
            end
            ST_TD: begin
                td_next    = sat_val(td_sum);
                state_next = ST_MULC;
            end
            ST_MULC: begin
                prod_next  = mul_out;
                state_next = ST_MULA;
            end
            ST_MULA: begin
                nv_next    = sat_val(nv_sum);
                prod_next  = mul_out;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                // hold until the result register is free
                if (out_free) begin
                    crit_wr_en   = 1'b1;
                    pref_wr_en   = 1'b1;
                    m_valid_next = 1'b1;
                    m_td_next    = td_reg;
                    m_nv_next    = nv_reg;
                    m_np_next    = np_val[tacu_pkg::PREF_W-1:0];
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        act_reg    <= act_next;
        reward_reg <= reward_next;
        td_reg     <= td_next;
        prod_reg   <= prod_next;
        nv_reg     <= nv_next;
        m_td_reg   <= m_td_next;
        m_nv_reg   <= m_nv_next;
        m_np_reg   <= m_np_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_td_error        = m_td_reg;
    assign m_new_state_value = m_nv_reg;
    assign m_new_preference  = m_np_reg;

endmodule
`default_nettype wire

[src/tabular_actor_critic_update.sv]
`default_nettype none
// A request is taken only while idle: the next one waits for the serial read,
// three uses of the shared multiplier and the write-back into the two table
// memories, and write-back waits while the result register is still full.
// Reset: registers return to defaults, then a clearing pass over all
// GRID_ROWS*GRID_COLS cells (1024 by default) fills both tables with
// s_ready low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// tabular_actor_critic_update
// Tabular TD(0) actor-critic update: TD error, critic and preference update.
// ----------------------------------------------------------------------------
module tabular_actor_critic_update #(
    parameter int GRID_ROWS = tacu_pkg::DEF_GRID_ROWS,
    parameter int GRID_COLS = tacu_pkg::DEF_GRID_COLS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tacu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tacu_pkg::RATE_W-1:0]         cfg_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [tacu_pkg::COORD_W-1:0]        s_cur_row,
    input  wire logic [tacu_pkg::COORD_W-1:0]        s_cur_col,
    input  wire logic [tacu_pkg::ACT_W-1:0]          s_action,
    input  wire logic signed [tacu_pkg::VAL_W-1:0]   s_reward,
    input  wire logic [tacu_pkg::COORD_W-1:0]        s_next_row,
    input  wire logic [tacu_pkg::COORD_W-1:0]        s_next_col,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [tacu_pkg::VAL_W-1:0]        m_td_error,
    output logic signed [tacu_pkg::VAL_W-1:0]        m_new_state_value,
    output logic [tacu_pkg::PREF_W-1:0]              m_new_preference
);

    localparam int NCELLS = GRID_ROWS * GRID_COLS;
    localparam int CELL_W = $clog2(NCELLS);

    tacu_pkg::cfg_t              cfg_reg, cfg_next;
    logic [tacu_pkg::RATE_W-1:0] cfg_clamped;

    logic                        crit_rd_en;
    logic [CELL_W-1:0]           crit_rd_addr_a;
    logic [CELL_W-1:0]           crit_rd_addr_b;
    logic [tacu_pkg::VAL_W-1:0]  crit_rd_data_a;
    logic [tacu_pkg::VAL_W-1:0]  crit_rd_data_b;
    logic                        crit_wr_en;
    logic [CELL_W-1:0]           crit_wr_addr;
    logic [tacu_pkg::VAL_W-1:0]  crit_wr_data;
    logic                        pref_rd_en;
    logic [CELL_W-1:0]           pref_rd_addr;
    tacu_pkg::pref_row_t         pref_rd_data;
    logic                        pref_wr_en;
    logic [CELL_W-1:0]           pref_wr_addr;
    tacu_pkg::pref_row_t         pref_wr_data;

    assign cfg_ready   = 1'b1;
    // values above 1.0 saturate to 1.0
    assign cfg_clamped = (cfg_data > tacu_pkg::Q_ONE) ? tacu_pkg::Q_ONE : cfg_data;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                tacu_pkg::CFG_DISCOUNT:    cfg_next.discount    = cfg_clamped;
                tacu_pkg::CFG_CRITIC_RATE: cfg_next.critic_rate = cfg_clamped;
                tacu_pkg::CFG_ACTOR_RATE:  cfg_next.actor_rate  = cfg_clamped;
                tacu_pkg::CFG_PREF_FLOOR:  cfg_next.pref_floor  = cfg_clamped;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.discount    <= tacu_pkg::DISCOUNT_RST;
            cfg_reg.critic_rate <= tacu_pkg::CRITIC_RATE_RST;
            cfg_reg.actor_rate  <= tacu_pkg::ACTOR_RATE_RST;
            cfg_reg.pref_floor  <= tacu_pkg::PREF_FLOOR_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    tacu_critic_mem #(
        .DEPTH (NCELLS)
    ) u_critic_mem (
        .aclk      (aclk),
        .wr_en     (crit_wr_en),
        .wr_addr   (crit_wr_addr),
        .wr_data   (crit_wr_data),
        .rd_en     (crit_rd_en),
        .rd_addr_a (crit_rd_addr_a),
        .rd_addr_b (crit_rd_addr_b),
        .rd_data_a (crit_rd_data_a),
        .rd_data_b (crit_rd_data_b)
    );

    tacu_pref_mem #(
        .DEPTH (NCELLS)
    ) u_pref_mem (
        .aclk    (aclk),
        .wr_en   (pref_wr_en),
        .wr_addr (pref_wr_addr),
        .wr_data (pref_wr_data),
        .rd_en   (pref_rd_en),
        .rd_addr (pref_rd_addr),
        .rd_data (pref_rd_data)
    );

    tacu_ctrl #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cur_row         (s_cur_row),
        .s_cur_col         (s_cur_col),
        .s_action          (s_action),
        .s_reward          (s_reward),
        .s_next_row        (s_next_row),
        .s_next_col        (s_next_col),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_td_error        (m_td_error),
        .m_new_state_value (m_new_state_value),
        .m_new_preference  (m_new_preference),
        .crit_rd_en        (crit_rd_en),
        .crit_rd_addr_a    (crit_rd_addr_a),
        .crit_rd_addr_b    (crit_rd_addr_b),
        .crit_rd_data_a    (crit_rd_data_a),
        .crit_rd_data_b    (crit_rd_data_b),
        .crit_wr_en        (crit_wr_en),
        .crit_wr_addr      (crit_wr_addr),
        .crit_wr_data      (crit_wr_data),
        .pref_rd_en        (pref_rd_en),
        .pref_rd_addr      (pref_rd_addr),
        .pref_rd_data      (pref_rd_data),
        .pref_wr_en        (pref_wr_en),
        .pref_wr_addr      (pref_wr_addr),
        .pref_wr_data      (pref_wr_data)
    );

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tabular actor-critic update block.
// Feeds grid transitions through the request channel, predicts the TD error,
// the new critic value and the new preference from a private copy of both
// tables, and compares every result field by field. Register settings are
// changed between phases while the block is idle; both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import tacu_pkg::*;

    localparam int ROWS          = DEF_GRID_ROWS;
    localparam int COLS          = DEF_GRID_COLS;
    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 80;

    localparam logic signed [VAL_W-1:0] REWARD_MAX = 24'sh7FFFFF;
    localparam logic signed [VAL_W-1:0] REWARD_MIN = 24'sh800000;
    localparam logic signed [VAL_W-1:0] REWARD_ONE = 24'sd65536;

    // indexes past the last register, expected to be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int READY_ALWAYS = 0;
    localparam int READY_RANDOM = 1;
    localparam int READY_RUNS   = 2;

    typedef enum logic [ACT_W-1:0] {MOVE_UP, MOVE_DOWN, MOVE_LEFT, MOVE_RIGHT} move_t;

    typedef struct packed {
        logic [COORD_W-1:0]      cur_row;
        logic [COORD_W-1:0]      cur_col;
        logic [ACT_W-1:0]        action;
        logic signed [VAL_W-1:0] reward;
        logic [COORD_W-1:0]      next_row;
        logic [COORD_W-1:0]      next_col;
    } transition_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] err;
        logic signed [VAL_W-1:0] state_value;
        logic [PREF_W-1:0]       preference;
    } update_t;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [RATE_W-1:0]       cfg_data  = '0;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    logic [COORD_W-1:0]      s_cur_row  = '0;
    logic [COORD_W-1:0]      s_cur_col  = '0;
    logic [ACT_W-1:0]        s_action   = '0;
    logic signed [VAL_W-1:0] s_reward   = '0;
    logic [COORD_W-1:0]      s_next_row = '0;
    logic [COORD_W-1:0]      s_next_col = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    logic signed [VAL_W-1:0] m_td_error;
    logic signed [VAL_W-1:0] m_new_state_value;
    logic [PREF_W-1:0]       m_new_preference;

    tabular_actor_critic_update u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cur_row         (s_cur_row),
        .s_cur_col         (s_cur_col),
        .s_action          (s_action),
        .s_reward          (s_reward),
        .s_next_row        (s_next_row),
        .s_next_col        (s_next_col),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_td_error        (m_td_error),
        .m_new_state_value (m_new_state_value),
        .m_new_preference  (m_new_preference)
    );

    // private copy of the tables and registers
    logic signed [VAL_W-1:0] critic_tbl [0:ROWS*COLS-1];
    logic [VAL_W-1:0]        pref_tbl   [0:ROWS*COLS*NUM_ACTIONS-1];
    logic [RATE_W-1:0]       discount_q = DISCOUNT_RST;
    logic [RATE_W-1:0]       critic_q   = CRITIC_RATE_RST;
    logic [RATE_W-1:0]       actor_q    = ACTOR_RATE_RST;
    logic [RATE_W-1:0]       floor_q    = PREF_FLOOR_RST;

    transition_t pending_q [$];
    update_t     update_q  [$];
    transition_t drv_item  = '0;

    int items_queued   = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int errors         = 0;
    int cfg_writes     = 0;
    int settings       = 1;
    int td_clipped     = 0;
    int floor_hits     = 0;
    int gap_max        = 0;
    int ready_style    = READY_ALWAYS;
    int gap_left       = 0;
    int burst_left     = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic longint clip24(longint v);
        if (v > longint'(REWARD_MAX)) return longint'(REWARD_MAX);
        if (v < longint'(REWARD_MIN)) return longint'(REWARD_MIN);
        return v;
    endfunction

    // rate * value with the rate in Q1.16, rounded half up; >>> floors on a signed operand
    function automatic longint scale_q16(logic [RATE_W-1:0] rate, longint v);
        longint p;
        p = longint'(rate) * v + 32768;
        return p >>> 16;
    endfunction

    function automatic int cell_of(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
        int rr, cc;
        rr = (r >= ROWS) ? ROWS - 1 : r;
        cc = (c >= COLS) ? COLS - 1 : c;
        return rr * COLS + cc;
    endfunction

    // apply one transition to the private tables and return the expected result
    function automatic update_t td_update(transition_t t);
        int      cur, nxt, slot;
        longint  v_cur, v_next, raw_td, td, nv, np;
        update_t res;
        cur    = cell_of(t.cur_row, t.cur_col);
        nxt    = cell_of(t.next_row, t.next_col);
        slot   = cur * NUM_ACTIONS + t.action;
        v_cur  = longint'(critic_tbl[cur]);
        v_next = longint'(critic_tbl[nxt]);
        raw_td = longint'($signed(t.reward)) + scale_q16(discount_q, v_next) - v_cur;
        td     = clip24(raw_td);
        if (td != raw_td) td_clipped++;
        nv = clip24(v_cur + scale_q16(critic_q, td));
        np = clip24(longint'(pref_tbl[slot]) + scale_q16(actor_q, td));
        if (np < longint'(floor_q)) begin
            np = longint'(floor_q);
            floor_hits++;
        end
        critic_tbl[cur] = nv[VAL_W-1:0];
        pref_tbl[slot]  = np[VAL_W-1:0];
        res.err         = td[VAL_W-1:0];
        res.state_value = nv[VAL_W-1:0];
        res.preference  = np[PREF_W-1:0];
        return res;
    endfunction

    // driver: bursts of requests separated by random gaps
    always @(posedge aclk) begin : drive_requests
        transition_t fresh;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                update_q.insert(update_q.size(), td_update(drv_item));
                items_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    fresh = pending_q.pop_front();
                    drv_item   <= fresh;
                    s_cur_row  <= fresh.cur_row;
                    s_cur_col  <= fresh.cur_col;
                    s_action   <= fresh.action;
                    s_reward   <= fresh.reward;
                    s_next_row <= fresh.next_row;
                    s_next_col <= fresh.next_col;
                    s_valid    <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left   <= (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else begin
            case (ready_style)
                READY_ALWAYS: begin
                    m_ready <= 1'b1;
                end
                READY_RANDOM: begin
                    m_ready <= ($urandom_range(0, 2) != 0);
                end
                default: begin
                    if (hold_left == 0) begin
                        m_ready   <= ~m_ready;
                        hold_left <= m_ready ? $urandom_range(1, 12) : $urandom_range(1, 6);
                    end else begin
                        hold_left <= hold_left - 1;
                    end
                end
            endcase
        end
    end

    task automatic check_field(input string label, input longint got, input longint want);
        if (got != want) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    // monitor: compare each result with the oldest prediction
    always @(posedge aclk) begin : check_results
        update_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (update_q.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result, TD error %0d", $time, m_td_error);
            end else begin
                want = update_q.pop_front();
                check_field("TD error", longint'(m_td_error), longint'(want.err));
                check_field("new_state_value", longint'(m_new_state_value),
                            longint'(want.state_value));
                check_field("new_preference", longint'(m_new_preference),
                            longint'(want.preference));
            end
        end
    end

    // watchdog: abort when no channel moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("[tabular_actor_critic_update] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // call only just after aclk rises
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] data);
        logic [RATE_W-1:0] held;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        held = (data > Q_ONE) ? Q_ONE : data;
        case (idx)
            CFG_DISCOUNT:    discount_q = held;
            CFG_CRITIC_RATE: critic_q   = held;
            CFG_ACTOR_RATE:  actor_q    = held;
            CFG_PREF_FLOOR:  floor_q    = held;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic add_item(input int cr, input int cc, input move_t act,
                            input logic signed [VAL_W-1:0] rw, input int nr, input int nc);
        transition_t t;
        t.cur_row  = COORD_W'(cr);
        t.cur_col  = COORD_W'(cc);
        t.action   = act;
        t.reward   = rw;
        t.next_row = COORD_W'(nr);
        t.next_col = COORD_W'(nc);
        pending_q.insert(pending_q.size(), t);
        items_queued++;
    endtask

    task automatic wait_drained();
        while (results_seen < items_queued) @(posedge aclk);
    endtask

    function automatic logic [RATE_W-1:0] random_rate();
        if ($urandom_range(0, 7) == 0) return RATE_W'($urandom);
        return RATE_W'($urandom_range(0, 65536));
    endfunction

    // mostly moves inside a 4x4 patch so values build up; some pure noise
    function automatic transition_t random_transition(int base_r, int base_c);
        transition_t t;
        int          r, c, roll;
        t.action = ACT_W'($urandom_range(0, 3));
        roll     = $urandom_range(0, 99);
        if (roll < 15) begin
            t.cur_row  = COORD_W'($urandom_range(0, 31));
            t.cur_col  = COORD_W'($urandom_range(0, 31));
            t.next_row = COORD_W'($urandom_range(0, 31));
            t.next_col = COORD_W'($urandom_range(0, 31));
        end else begin
            r = base_r + $urandom_range(0, 3);
            c = base_c + $urandom_range(0, 3);
            t.cur_row = COORD_W'(r);
            t.cur_col = COORD_W'(c);
            if (roll < 25) begin
                // bump into a wall: stay put
            end else begin
                case (move_t'(t.action))
                    MOVE_UP:    r = (r == 0) ? 0 : r - 1;
                    MOVE_DOWN:  r = (r == ROWS - 1) ? r : r + 1;
                    MOVE_LEFT:  c = (c == 0) ? 0 : c - 1;
                    default:    c = (c == COLS - 1) ? c : c + 1;
                endcase
            end
            t.next_row = COORD_W'(r);
            t.next_col = COORD_W'(c);
        end
        roll = $urandom_range(0, 99);
        if (roll < 70)      t.reward = VAL_W'(int'($urandom_range(0, 262144)) - 131072);
        else if (roll < 75) t.reward = REWARD_MAX;
        else if (roll < 80) t.reward = REWARD_MIN;
        else                t.reward = VAL_W'($urandom);
        return t;
    endfunction

    initial begin : run_phases
        int p, k, base_r, base_c;
        for (k = 0; k < ROWS * COLS; k++) critic_tbl[k] = VAL_ZERO;
        for (k = 0; k < ROWS * COLS * NUM_ACTIONS; k++) pref_tbl[k] = PREF_RST;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // register defaults: corners, every move, reward extremes, self loops
        add_item(0, 0, MOVE_UP, '0, 0, 1);
        add_item(0, 0, MOVE_DOWN, REWARD_MAX, 0, 0);
        add_item(0, 0, MOVE_DOWN, REWARD_MAX, 0, 0);
        add_item(31, 31, MOVE_LEFT, REWARD_MIN, 0, 0);
        add_item(31, 31, MOVE_RIGHT, REWARD_MIN, 31, 31);
        add_item(0, 31, MOVE_UP, REWARD_ONE, 31, 0);
        add_item(31, 0, MOVE_RIGHT, -REWARD_ONE, 0, 31);
        add_item(21, 10, MOVE_LEFT, -24'sd1, 10, 21);
        add_item(10, 21, MOVE_DOWN, 24'sd1, 21, 10);
        add_item(0, 1, MOVE_UP, '0, 0, 0);
        wait_drained();

        // rates at 1.0 (one via an over-range write), floor at zero, spare indexes
        @(posedge aclk);
        write_reg(CFG_DISCOUNT, 17'h1FFFF);
        write_reg(CFG_CRITIC_RATE, Q_ONE);
        write_reg(CFG_ACTOR_RATE, Q_ONE);
        write_reg(CFG_PREF_FLOOR, '0);
        write_reg(CFG_SPARE_LO, '0);
        write_reg(CFG_SPARE_HI, 17'h1FFFF);
        cfg_valid <= 1'b0;
        settings++;
        for (k = 0; k < 4; k++) add_item(5, 5, move_t'(k), REWARD_MAX, 5, 5);
        for (k = 0; k < 4; k++) add_item(5, 5, MOVE_UP, REWARD_MIN, 5, 6);
        add_item(5, 6, MOVE_RIGHT, REWARD_MIN, 5, 5);
        wait_drained();

        // everything off, floor at 1.0: preference raised to the floor
        @(posedge aclk);
        write_reg(CFG_DISCOUNT, '0);
        write_reg(CFG_CRITIC_RATE, '0);
        write_reg(CFG_ACTOR_RATE, '0);
        write_reg(CFG_PREF_FLOOR, Q_ONE);
        cfg_valid <= 1'b0;
        settings++;
        add_item(5, 5, MOVE_UP, REWARD_MAX, 5, 5);
        add_item(5, 5, MOVE_DOWN, REWARD_MIN, 0, 0);
        add_item(31, 31, MOVE_LEFT, '0, 31, 31);
        wait_drained();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            @(posedge aclk);
            write_reg(CFG_DISCOUNT, random_rate());
            write_reg(CFG_CRITIC_RATE, random_rate());
            write_reg(CFG_ACTOR_RATE, random_rate());
            write_reg(CFG_PREF_FLOOR, random_rate());
            cfg_valid <= 1'b0;
            settings++;
            if (p == 0) begin
                gap_max     = 0;
                ready_style = READY_ALWAYS;
            end else begin
                gap_max     = $urandom_range(2, 20);
                ready_style = (p % 2 == 1) ? READY_RUNS : READY_RANDOM;
            end
            base_r = $urandom_range(0, ROWS - 4);
            base_c = $urandom_range(0, COLS - 4);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                pending_q.insert(pending_q.size(), random_transition(base_r, base_c));
                items_queued++;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (update_q.size() != 0) begin
            errors += update_q.size();
            $display("%0t ns: %0d results never arrived", $time, update_q.size());
        end
        $display("Ran %0d transitions under %0d register settings (%0d register writes).",
                 items_accepted, settings, cfg_writes);
        $display("TD error clipped %0d times, preference held at the floor %0d times.",
                 td_clipped, floor_hits);
        if (errors == 0) begin
            $display("[tabular_actor_critic_update] OK");
        end else begin
            $display("[tabular_actor_critic_update] ERROR");
        end
        $finish;
    end

endmodule
